@@ hdl/jptl_pkg.sv @@
`timescale 1ns / 1ps

package jptl_pkg;

   // Field widths
   localparam int LEG_W   = 2;
   localparam int KIND_W  = 2;
   localparam int LIMIT_W = 31;
   localparam int GAIN_W  = 31;
   localparam int DATA_W  = 32;
   localparam int ERR_W   = DATA_W + 1;
   localparam int PROD_W  = 64;
   localparam int SUM_W   = PROD_W + 2;
   localparam int CSR_INDEX_W = 3;

   // Default fixed point format
   localparam int FRAC_BITS_DEFAULT = 16;

   // Limit register reset values (Q16.16)
   localparam logic [LIMIT_W-1:0] FULL_ABAD_RESET = 31'd1179648;
   localparam logic [LIMIT_W-1:0] FULL_HIP_RESET  = 31'd1179648;
   localparam logic [LIMIT_W-1:0] FULL_KNEE_RESET = 31'd1835008;
   localparam logic [LIMIT_W-1:0] WEAK_ABAD_RESET = 31'd393216;
   localparam logic [LIMIT_W-1:0] WEAK_HIP_RESET  = 31'd393216;
   localparam logic [LIMIT_W-1:0] WEAK_KNEE_RESET = 31'd393216;

   // Configuration register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FULL_ABAD = 3'd0,
      CSR_FULL_HIP  = 3'd1,
      CSR_FULL_KNEE = 3'd2,
      CSR_WEAK_ABAD = 3'd3,
      CSR_WEAK_HIP  = 3'd4,
      CSR_WEAK_KNEE = 3'd5
   } csr_index_type;

   // Joint codes
   typedef enum logic [KIND_W-1:0] {
      JOINT_ABAD = 2'd0,
      JOINT_HIP  = 2'd1,
      JOINT_KNEE = 2'd2
   } joint_type;

   // One registered joint transaction handed to the datapath
   typedef struct packed {
      logic [LEG_W-1:0]          leg;
      logic [GAIN_W-1:0]         gain_p;
      logic [GAIN_W-1:0]         gain_d;
      logic signed [ERR_W-1:0]   pos_err;
      logic signed [ERR_W-1:0]   vel_err;
      logic signed [DATA_W-1:0]  ff;
      logic [LIMIT_W-1:0]        limit;
   } item_type;

endpackage

@@ hdl/jptl_pd_core.sv @@
`timescale 1ns / 1ps

module jptl_pd_core #(
   parameter int FRAC_BITS = jptl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  jptl_pkg::item_type                item,
   output logic                              out_valid,
   output logic [jptl_pkg::LEG_W-1:0]        out_leg,
   output logic signed [jptl_pkg::DATA_W-1:0] out_torque
);

   // Product stage
   logic                                   prod_valid_ff;
   logic signed [jptl_pkg::PROD_W-1:0]     prod_p_ff, prod_p_in;
   logic signed [jptl_pkg::PROD_W-1:0]     prod_d_ff, prod_d_in;
   logic signed [jptl_pkg::DATA_W-1:0]     ff_ff;
   logic [jptl_pkg::LIMIT_W-1:0]           limit_ff;
   logic [jptl_pkg::LEG_W-1:0]             leg_ff;

   // Result stage
   logic                                   out_valid_ff;
   logic [jptl_pkg::LEG_W-1:0]             out_leg_ff;
   logic signed [jptl_pkg::DATA_W-1:0]     out_torque_ff, out_torque_in;
   logic [jptl_pkg::LIMIT_W-1:0]           out_limit_ff;

   logic signed [jptl_pkg::PROD_W-1:0]     p_shift, d_shift;
   logic signed [jptl_pkg::SUM_W-1:0]      sum, lim_pos, lim_neg;

   // Gain times error, exact at 64 bits
   assign prod_p_in = $signed({1'b0, item.gain_p}) * item.pos_err;
   assign prod_d_in = $signed({1'b0, item.gain_d}) * item.vel_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= item_valid;
      end
      prod_p_ff <= prod_p_in;
      prod_d_ff <= prod_d_in;
      ff_ff     <= item.ff;
      limit_ff  <= item.limit;
      leg_ff    <= item.leg;
   end

   // Floor scaling, exact sum, symmetric clamp
   assign p_shift = prod_p_ff >>> FRAC_BITS;
   assign d_shift = prod_d_ff >>> FRAC_BITS;
   assign sum = jptl_pkg::SUM_W'(p_shift) + jptl_pkg::SUM_W'(d_shift)
              + jptl_pkg::SUM_W'(ff_ff);
   assign lim_pos = $signed({{(jptl_pkg::SUM_W-jptl_pkg::LIMIT_W){1'b0}}, limit_ff});
   assign lim_neg = -lim_pos;

   always_comb begin
      priority if (sum > lim_pos) begin
         out_torque_in = lim_pos[jptl_pkg::DATA_W-1:0];
      end else if (sum < lim_neg) begin
         out_torque_in = lim_neg[jptl_pkg::DATA_W-1:0];
      end else begin
         out_torque_in = sum[jptl_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= prod_valid_ff;
      end
      out_leg_ff    <= leg_ff;
      out_torque_ff <= out_torque_in;
      out_limit_ff  <= limit_ff;
   end

   assign out_valid  = out_valid_ff;
   assign out_leg    = out_leg_ff;
   assign out_torque = out_torque_ff;

   // Result never leaves the band set by its own limit
   a_torque_in_band: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         ($signed({out_torque_ff[jptl_pkg::DATA_W-1], out_torque_ff}) <=
          $signed({2'b00, out_limit_ff})) &&
         ($signed({out_torque_ff[jptl_pkg::DATA_W-1], out_torque_ff}) >=
          -$signed({2'b00, out_limit_ff})))
      else $error("torque outside limit band");

   // Zero limit always gives zero torque
   a_zero_limit: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_limit_ff == '0)) |-> (out_torque_ff == '0))
      else $error("nonzero torque under zero limit");

endmodule

@@ hdl/joint_pd_torque_limiter_unit.sv @@
`timescale 1ns / 1ps

// Joint PD torque limiter. Each transaction carries one joint command; the
// unit returns torque = kp*(pos error) + kd*(vel error) + feedforward in
// signed fixed point, clamped to +/- the joint limit chosen by joint_kind,
// enable and weak_mode (zero when disabled or for an unused joint code).
// busy stays low: a new transaction is taken every cycle. The result shows
// on rsp_* with rsp_strobe high for exactly one cycle; the receiver cannot
// stall it and must take it then. The result passes through the input
// register, the registered 31x33 multipliers and the sum/clamp result
// register. The user must write limit registers via csr_* only while no
// transaction is in flight; the block itself does not enforce this.
module joint_pd_torque_limiter_unit #(
   parameter int FRAC_BITS = jptl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Command channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [jptl_pkg::LEG_W-1:0]           req_leg_tag,
   input  logic [jptl_pkg::KIND_W-1:0]          req_joint_kind,
   input  logic [jptl_pkg::GAIN_W-1:0]          req_gain_p,
   input  logic [jptl_pkg::GAIN_W-1:0]          req_gain_d,
   input  logic signed [jptl_pkg::DATA_W-1:0]   req_target_position,
   input  logic signed [jptl_pkg::DATA_W-1:0]   req_measured_position,
   input  logic signed [jptl_pkg::DATA_W-1:0]   req_target_velocity,
   input  logic signed [jptl_pkg::DATA_W-1:0]   req_measured_velocity,
   input  logic signed [jptl_pkg::DATA_W-1:0]   req_feedforward,
   input  logic                                 req_enable,
   input  logic                                 req_weak_mode,
   // Result channel
   output logic                                 rsp_strobe,
   output logic [jptl_pkg::LEG_W-1:0]           rsp_leg_echo,
   output logic signed [jptl_pkg::DATA_W-1:0]   rsp_torque,
   // Configuration port
   input  logic                                 csr_we,
   input  logic [jptl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [jptl_pkg::LIMIT_W-1:0]         csr_wdata
);

   logic [jptl_pkg::LIMIT_W-1:0] full_abad_ff, full_hip_ff, full_knee_ff;
   logic [jptl_pkg::LIMIT_W-1:0] weak_abad_ff, weak_hip_ff, weak_knee_ff;

   logic                 accept;
   logic                 item_valid_ff;
   jptl_pkg::item_type   item_ff, item_in;
   logic [jptl_pkg::LIMIT_W-1:0] full_sel, weak_sel, limit_sel;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         full_abad_ff <= jptl_pkg::FULL_ABAD_RESET;
         full_hip_ff  <= jptl_pkg::FULL_HIP_RESET;
         full_knee_ff <= jptl_pkg::FULL_KNEE_RESET;
         weak_abad_ff <= jptl_pkg::WEAK_ABAD_RESET;
         weak_hip_ff  <= jptl_pkg::WEAK_HIP_RESET;
         weak_knee_ff <= jptl_pkg::WEAK_KNEE_RESET;
      end else if (csr_we) begin
         unique case (jptl_pkg::csr_index_type'(csr_index))
            jptl_pkg::CSR_FULL_ABAD: full_abad_ff <= csr_wdata;
            jptl_pkg::CSR_FULL_HIP:  full_hip_ff  <= csr_wdata;
            jptl_pkg::CSR_FULL_KNEE: full_knee_ff <= csr_wdata;
            jptl_pkg::CSR_WEAK_ABAD: weak_abad_ff <= csr_wdata;
            jptl_pkg::CSR_WEAK_HIP:  weak_hip_ff  <= csr_wdata;
            jptl_pkg::CSR_WEAK_KNEE: weak_knee_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Per-joint limit select
   always_comb begin
      unique case (jptl_pkg::joint_type'(req_joint_kind))
         jptl_pkg::JOINT_ABAD: begin
            full_sel = full_abad_ff;
            weak_sel = weak_abad_ff;
         end
         jptl_pkg::JOINT_HIP: begin
            full_sel = full_hip_ff;
            weak_sel = weak_hip_ff;
         end
         jptl_pkg::JOINT_KNEE: begin
            full_sel = full_knee_ff;
            weak_sel = weak_knee_ff;
         end
         default: begin
            full_sel = '0;
            weak_sel = '0;
         end
      endcase
      if (!req_enable) begin
         limit_sel = '0;
      end else if (req_weak_mode) begin
         limit_sel = weak_sel;
      end else begin
         limit_sel = full_sel;
      end
   end

   // Input register: errors formed exactly at 33 bits
   always_comb begin
      item_in.leg     = req_leg_tag;
      item_in.gain_p  = req_gain_p;
      item_in.gain_d  = req_gain_d;
      item_in.pos_err = jptl_pkg::ERR_W'(req_target_position)
                      - jptl_pkg::ERR_W'(req_measured_position);
      item_in.vel_err = jptl_pkg::ERR_W'(req_target_velocity)
                      - jptl_pkg::ERR_W'(req_measured_velocity);
      item_in.ff      = req_feedforward;
      item_in.limit   = limit_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   jptl_pd_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .out_valid  (rsp_strobe),
      .out_leg    (rsp_leg_echo),
      .out_torque (rsp_torque)
   );

   // Every result strobe traces back to an accepted transaction
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3))
      else $error("result strobe without a transaction");

   // Leg tag travels with its transaction
   a_leg_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_leg_echo == $past(req_leg_tag, 3)))
      else $error("leg echo mismatch");

   // A disabled joint registers a zero limit
   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_enable) |=> (item_ff.limit == '0))
      else $error("disabled joint with nonzero limit");

endmodule

@@ dv/joint_pd_torque_limiter_checker.sv @@
`timescale 1ns / 1ps

// Watches the command, result and limit write ports of the joint torque unit.
// Keeps its own copy of the six limit registers, predicts the clamped PD
// torque of every accepted transaction and compares it with the results in order.
module joint_pd_torque_limiter_checker #(
   parameter int FRAC_BITS = jptl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [jptl_pkg::LEG_W-1:0]         req_leg_tag,
   input  logic [jptl_pkg::KIND_W-1:0]        req_joint_kind,
   input  logic [jptl_pkg::GAIN_W-1:0]        req_gain_p,
   input  logic [jptl_pkg::GAIN_W-1:0]        req_gain_d,
   input  logic signed [jptl_pkg::DATA_W-1:0] req_target_position,
   input  logic signed [jptl_pkg::DATA_W-1:0] req_measured_position,
   input  logic signed [jptl_pkg::DATA_W-1:0] req_target_velocity,
   input  logic signed [jptl_pkg::DATA_W-1:0] req_measured_velocity,
   input  logic signed [jptl_pkg::DATA_W-1:0] req_feedforward,
   input  logic                               req_enable,
   input  logic                               req_weak_mode,
   input  logic                               rsp_strobe,
   input  logic [jptl_pkg::LEG_W-1:0]         rsp_leg_echo,
   input  logic signed [jptl_pkg::DATA_W-1:0] rsp_torque,
   input  logic                               csr_we,
   input  logic [jptl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [jptl_pkg::LIMIT_W-1:0]       csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);

   typedef struct {
      logic [jptl_pkg::LEG_W-1:0]         leg;
      logic signed [jptl_pkg::DATA_W-1:0] torque;
   } torque_result_type;

   torque_result_type            torque_q[$];
   logic [jptl_pkg::LIMIT_W-1:0] full_lim [3];
   logic [jptl_pkg::LIMIT_W-1:0] weak_lim [3];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // One line per mismatch
   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // Clamped PD torque: each product floored by FRAC_BITS, summed wide
   function automatic logic signed [jptl_pkg::DATA_W-1:0] predict_torque(
      input logic [jptl_pkg::KIND_W-1:0]        kind,
      input logic [jptl_pkg::GAIN_W-1:0]        kp,
      input logic [jptl_pkg::GAIN_W-1:0]        kd,
      input logic signed [jptl_pkg::DATA_W-1:0] tp,
      input logic signed [jptl_pkg::DATA_W-1:0] mp,
      input logic signed [jptl_pkg::DATA_W-1:0] tv,
      input logic signed [jptl_pkg::DATA_W-1:0] mv,
      input logic signed [jptl_pkg::DATA_W-1:0] ff,
      input logic                               en,
      input logic                               use_weak
   );
      longint pos_err;
      longint vel_err;
      longint total;
      longint lim;
      pos_err = longint'(tp) - longint'(mp);
      vel_err = longint'(tv) - longint'(mv);
      total = ((longint'(kp) * pos_err) >>> FRAC_BITS)
            + ((longint'(kd) * vel_err) >>> FRAC_BITS) + longint'(ff);
      lim = 0;
      if (en) begin
         case (kind)
            jptl_pkg::JOINT_ABAD, jptl_pkg::JOINT_HIP, jptl_pkg::JOINT_KNEE: begin
               lim = longint'(use_weak ? weak_lim[kind] : full_lim[kind]);
            end
            default: lim = 0;   // unused joint code selects no limit
         endcase
      end
      if (total > lim) total = lim;
      if (total < -lim) total = -lim;
      return total[jptl_pkg::DATA_W-1:0];
   endfunction

   always @(posedge clock) begin
      torque_result_type want;
      if (reset) begin
         full_lim[jptl_pkg::JOINT_ABAD] <= jptl_pkg::FULL_ABAD_RESET;
         full_lim[jptl_pkg::JOINT_HIP]  <= jptl_pkg::FULL_HIP_RESET;
         full_lim[jptl_pkg::JOINT_KNEE] <= jptl_pkg::FULL_KNEE_RESET;
         weak_lim[jptl_pkg::JOINT_ABAD] <= jptl_pkg::WEAK_ABAD_RESET;
         weak_lim[jptl_pkg::JOINT_HIP]  <= jptl_pkg::WEAK_HIP_RESET;
         weak_lim[jptl_pkg::JOINT_KNEE] <= jptl_pkg::WEAK_KNEE_RESET;
         torque_q.delete();
      end else begin
         // Limit register writes; indexes past the map are dropped
         if (csr_we) begin
            case (csr_index)
               jptl_pkg::CSR_FULL_ABAD: full_lim[jptl_pkg::JOINT_ABAD] <= csr_wdata;
               jptl_pkg::CSR_FULL_HIP:  full_lim[jptl_pkg::JOINT_HIP]  <= csr_wdata;
               jptl_pkg::CSR_FULL_KNEE: full_lim[jptl_pkg::JOINT_KNEE] <= csr_wdata;
               jptl_pkg::CSR_WEAK_ABAD: weak_lim[jptl_pkg::JOINT_ABAD] <= csr_wdata;
               jptl_pkg::CSR_WEAK_HIP:  weak_lim[jptl_pkg::JOINT_HIP]  <= csr_wdata;
               jptl_pkg::CSR_WEAK_KNEE: weak_lim[jptl_pkg::JOINT_KNEE] <= csr_wdata;
               default: ;
            endcase
         end

         // Result side: compare against the oldest prediction
         if (rsp_strobe) begin
            if (torque_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result leg %0d torque %0d",
                                         rsp_leg_echo, rsp_torque));
            end else begin
               want = torque_q.pop_front();
               if (rsp_leg_echo !== want.leg) begin
                  report_mismatch($sformatf("leg_echo got %0d expected %0d",
                                            rsp_leg_echo, want.leg));
               end
               if (rsp_torque !== want.torque) begin
                  report_mismatch($sformatf("torque got %0d (%h) expected %0d (%h)",
                                            rsp_torque, rsp_torque,
                                            want.torque, want.torque));
               end
            end
         end

         // Command side: predict every accepted transaction
         if (start && !busy) begin
            want.leg    = req_leg_tag;
            want.torque = predict_torque(req_joint_kind, req_gain_p, req_gain_d,
                                         req_target_position, req_measured_position,
                                         req_target_velocity, req_measured_velocity,
                                         req_feedforward, req_enable, req_weak_mode);
            torque_q.push_back(want);
         end
      end
      outstanding <= torque_q.size();
   end

endmodule

@@ dv/tb_joint_pd_torque_limiter_unit.sv @@
`timescale 1ns / 1ps

module tb_joint_pd_torque_limiter_unit;

   // Codes outside the package maps
   localparam logic [jptl_pkg::KIND_W-1:0]      JOINT_NONE  = 2'd3;
   localparam logic [jptl_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [jptl_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   // Q16.16 shorthands
   localparam logic signed [jptl_pkg::DATA_W-1:0] Q_ONE    = 32'sh0001_0000;
   localparam logic signed [jptl_pkg::DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [jptl_pkg::DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
   localparam logic [jptl_pkg::GAIN_W-1:0]        GAIN_MAX = 31'h7FFF_FFFF;
   localparam logic [jptl_pkg::LIMIT_W-1:0]       LIM_MAX  = 31'h7FFF_FFFF;
   localparam logic signed [jptl_pkg::DATA_W-1:0] ABAD_FULL_Q =
      {1'b0, jptl_pkg::FULL_ABAD_RESET};

   localparam int ITEMS_PER_PHASE = 285;
   localparam int SETTLE_CYCLES   = 4;

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [jptl_pkg::LEG_W-1:0]         req_leg_tag = '0;
   logic [jptl_pkg::KIND_W-1:0]        req_joint_kind = '0;
   logic [jptl_pkg::GAIN_W-1:0]        req_gain_p = '0;
   logic [jptl_pkg::GAIN_W-1:0]        req_gain_d = '0;
   logic signed [jptl_pkg::DATA_W-1:0] req_target_position = '0;
   logic signed [jptl_pkg::DATA_W-1:0] req_measured_position = '0;
   logic signed [jptl_pkg::DATA_W-1:0] req_target_velocity = '0;
   logic signed [jptl_pkg::DATA_W-1:0] req_measured_velocity = '0;
   logic signed [jptl_pkg::DATA_W-1:0] req_feedforward = '0;
   logic                               req_enable = 1'b0;
   logic                               req_weak_mode = 1'b0;
   logic                               rsp_strobe;
   logic [jptl_pkg::LEG_W-1:0]         rsp_leg_echo;
   logic signed [jptl_pkg::DATA_W-1:0] rsp_torque;
   logic                               csr_we = 1'b0;
   logic [jptl_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [jptl_pkg::LIMIT_W-1:0]       csr_wdata = '0;
   int                                 mismatches;
   int                                 outstanding;
   bit                                 steady = 1'b0;

   jptl_pkg::csr_index_type limit_regs [6] = '{
      jptl_pkg::CSR_FULL_ABAD, jptl_pkg::CSR_FULL_HIP, jptl_pkg::CSR_FULL_KNEE,
      jptl_pkg::CSR_WEAK_ABAD, jptl_pkg::CSR_WEAK_HIP, jptl_pkg::CSR_WEAK_KNEE};

   joint_pd_torque_limiter_unit dut (.*);

   joint_pd_torque_limiter_checker torque_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Mostly back-to-back or short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Signed word with a random magnitude scale
   function automatic logic signed [jptl_pkg::DATA_W-1:0] spread_word();
      logic [jptl_pkg::DATA_W-1:0] w;
      w = $urandom;
      return $signed(w) >>> $urandom_range(0, 31);
   endfunction

   function automatic logic [jptl_pkg::GAIN_W-1:0] pick_gain();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 9) != 0) w = w >> $urandom_range(8, 31);
      return w[jptl_pkg::GAIN_W-1:0];
   endfunction

   function automatic logic [jptl_pkg::LIMIT_W-1:0] random_limit();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return LIM_MAX;
         2:       return jptl_pkg::LIMIT_W'($urandom_range(0, 40 * 65536));
         default: return w[jptl_pkg::LIMIT_W-1:0];
      endcase
   endfunction

   // Present one command transaction and hold it until accepted
   task automatic send_joint(
      input logic [jptl_pkg::LEG_W-1:0]         leg,
      input logic [jptl_pkg::KIND_W-1:0]        kind,
      input logic [jptl_pkg::GAIN_W-1:0]        kp,
      input logic [jptl_pkg::GAIN_W-1:0]        kd,
      input logic signed [jptl_pkg::DATA_W-1:0] tp,
      input logic signed [jptl_pkg::DATA_W-1:0] mp,
      input logic signed [jptl_pkg::DATA_W-1:0] tv,
      input logic signed [jptl_pkg::DATA_W-1:0] mv,
      input logic signed [jptl_pkg::DATA_W-1:0] ff,
      input logic                               en,
      input logic                               use_weak
   );
      int gap;
      req_leg_tag           <= leg;
      req_joint_kind        <= kind;
      req_gain_p            <= kp;
      req_gain_d            <= kd;
      req_target_position   <= tp;
      req_measured_position <= mp;
      req_target_velocity   <= tv;
      req_measured_velocity <= mv;
      req_feedforward       <= ff;
      req_enable            <= en;
      req_weak_mode         <= use_weak;
      start                 <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_command();
      logic [jptl_pkg::KIND_W-1:0]        kind;
      logic signed [jptl_pkg::DATA_W-1:0] tp, mp, tv, mv;
      if ($urandom_range(0, 11) == 0) begin
         kind = JOINT_NONE;
      end else begin
         case ($urandom_range(0, 2))
            0:       kind = jptl_pkg::JOINT_ABAD;
            1:       kind = jptl_pkg::JOINT_HIP;
            default: kind = jptl_pkg::JOINT_KNEE;
         endcase
      end
      // errors are often small so that results land inside the limits
      tp = spread_word();
      mp = $urandom_range(0, 1) ? tp - (spread_word() >>> 6) : spread_word();
      tv = spread_word();
      mv = $urandom_range(0, 1) ? tv - (spread_word() >>> 6) : spread_word();
      send_joint(jptl_pkg::LEG_W'($urandom), kind, pick_gain(), pick_gain(),
                 tp, mp, tv, mv, spread_word(), $urandom_range(0, 6) != 0,
                 1'($urandom_range(0, 1)));
   endtask

   // Stop issuing and wait for the pipeline to empty
   task automatic settle_idle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [jptl_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [jptl_pkg::LIMIT_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset limits (full 18/18/28, weak 6)
      send_joint(0, jptl_pkg::JOINT_ABAD, 0, 0, 0, 0, 0, 0, 0, 1, 0);
      send_joint(1, jptl_pkg::JOINT_HIP, Q_ONE, 0, 2 * Q_ONE, 0, 0, 0, 0, 1, 0);
      send_joint(2, jptl_pkg::JOINT_KNEE, Q_ONE, 0, 0, 30 * Q_ONE, 0, 0, 0, 1, 0);
      send_joint(3, jptl_pkg::JOINT_ABAD, 0, 2 * Q_ONE, 0, 0, 5 * Q_ONE, -5 * Q_ONE,
                 0, 1, 0);
      send_joint(0, jptl_pkg::JOINT_HIP, Q_ONE, 0, 10 * Q_ONE, 0, 0, 0, 0, 1, 1);
      send_joint(1, jptl_pkg::JOINT_KNEE, GAIN_MAX, GAIN_MAX, DATA_MAX, DATA_MIN,
                 DATA_MAX, DATA_MIN, DATA_MAX, 0, 1);
      send_joint(2, JOINT_NONE, Q_ONE, 0, Q_ONE, 0, 0, 0, Q_ONE, 1, 0);
      // floor rounding of negative and positive sub-unit products
      send_joint(3, jptl_pkg::JOINT_HIP, 1, 0, -1, 0, 0, 0, 0, 1, 0);
      send_joint(0, jptl_pkg::JOINT_HIP, 1, 0, 1, 0, 0, 0, 0, 1, 0);
      send_joint(1, jptl_pkg::JOINT_ABAD, 0, 3, 0, 0, -1, 0, 5, 1, 0);
      send_joint(2, jptl_pkg::JOINT_ABAD, GAIN_MAX, 0, DATA_MAX, DATA_MIN, 0, 0, 0,
                 1, 0);
      send_joint(3, jptl_pkg::JOINT_ABAD, GAIN_MAX, 0, DATA_MIN, DATA_MAX, 0, 0, 0,
                 1, 0);
      // wide sum far beyond 32 bits
      send_joint(0, jptl_pkg::JOINT_KNEE, GAIN_MAX, GAIN_MAX, DATA_MAX, DATA_MIN,
                 DATA_MAX, DATA_MIN, DATA_MAX, 1, 0);
      send_joint(1, jptl_pkg::JOINT_KNEE, 0, 0, 0, 0, 0, 0, DATA_MAX, 1, 0);
      send_joint(2, jptl_pkg::JOINT_KNEE, 0, 0, 0, 0, 0, 0, DATA_MIN, 1, 0);
      // at and just past the limit on both sides
      send_joint(3, jptl_pkg::JOINT_ABAD, 0, 0, 0, 0, 0, 0, ABAD_FULL_Q, 1, 0);
      send_joint(0, jptl_pkg::JOINT_ABAD, 0, 0, 0, 0, 0, 0, ABAD_FULL_Q + 1, 1, 0);
      send_joint(1, jptl_pkg::JOINT_ABAD, 0, 0, 0, 0, 0, 0, -ABAD_FULL_Q, 1, 0);
      send_joint(2, jptl_pkg::JOINT_ABAD, 0, 0, 0, 0, 0, 0, -ABAD_FULL_Q - 1, 1, 0);

      // Directed: widest limits
      settle_idle();
      foreach (limit_regs[i]) write_limit(limit_regs[i], LIM_MAX);
      send_joint(3, jptl_pkg::JOINT_ABAD, 0, 0, 0, 0, 0, 0, DATA_MAX, 1, 0);
      send_joint(0, jptl_pkg::JOINT_HIP, 0, 0, 0, 0, 0, 0, DATA_MIN, 1, 0);
      send_joint(1, jptl_pkg::JOINT_KNEE, 0, 0, 0, 0, 0, 0, DATA_MIN, 1, 1);
      send_joint(2, jptl_pkg::JOINT_HIP, GAIN_MAX, GAIN_MAX, DATA_MAX, DATA_MIN,
                 DATA_MAX, DATA_MIN, DATA_MAX, 1, 1);
      send_joint(3, jptl_pkg::JOINT_KNEE, GAIN_MAX, GAIN_MAX, DATA_MIN, DATA_MAX,
                 DATA_MIN, DATA_MAX, DATA_MIN, 1, 0);

      // Random phases, each under its own limit setting
      for (phase = 0; phase < 6; phase++) begin
         settle_idle();
         case (phase)
            0: begin
               write_limit(jptl_pkg::CSR_FULL_ABAD, jptl_pkg::FULL_ABAD_RESET);
               write_limit(jptl_pkg::CSR_FULL_HIP, jptl_pkg::FULL_HIP_RESET);
               write_limit(jptl_pkg::CSR_FULL_KNEE, jptl_pkg::FULL_KNEE_RESET);
               write_limit(jptl_pkg::CSR_WEAK_ABAD, jptl_pkg::WEAK_ABAD_RESET);
               write_limit(jptl_pkg::CSR_WEAK_HIP, jptl_pkg::WEAK_HIP_RESET);
               write_limit(jptl_pkg::CSR_WEAK_KNEE, jptl_pkg::WEAK_KNEE_RESET);
            end
            1: foreach (limit_regs[i]) write_limit(limit_regs[i], LIM_MAX);
            2: foreach (limit_regs[i]) write_limit(limit_regs[i], '0);
            3: begin
               foreach (limit_regs[i]) begin
                  write_limit(limit_regs[i], jptl_pkg::LIMIT_W'($urandom));
               end
               // writes past the map must change nothing
               write_limit(CSR_SPARE_A, jptl_pkg::LIMIT_W'($urandom));
               write_limit(CSR_SPARE_B, LIM_MAX);
            end
            4: foreach (limit_regs[i]) begin
               write_limit(limit_regs[i],
                           jptl_pkg::LIMIT_W'($urandom_range(0, 40 * 65536)));
            end
            default: foreach (limit_regs[i]) write_limit(limit_regs[i], random_limit());
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 48 == 0) steady = ($urandom_range(0, 3) == 0);
            random_command();
         end
      end

      settle_idle();
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/jptl_pkg.sv
hdl/jptl_pd_core.sv
hdl/joint_pd_torque_limiter_unit.sv
dv/joint_pd_torque_limiter_checker.sv
dv/tb_joint_pd_torque_limiter_unit.sv
